@@ rtl/triangle_max_path_sum_defines.svh @@
// Assertion macros used by the sum stage of the triangle path-sum RTL.
`ifndef TRIANGLE_MAX_PATH_SUM_DEFINES_SVH
`define TRIANGLE_MAX_PATH_SUM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TMPS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TMPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tmps_pkg.sv @@
// Shared constants and types for the triangle max path sum block.
package tmps_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int VALUE_BITS = 16;
  localparam int OUT_BITS   = 22;
  localparam int SUM_W      = 23;
  localparam int CFG_W      = 7;
  localparam int CNT_W      = $clog2(MAX_ROWS + 1);
  localparam int IDX_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Per-entry sequencing flags handed from the row/column counters to the datapath
  typedef struct packed {
    logic has_left;   // left parent exists
    logic has_right;  // parent directly above exists
    logic bottom;     // entry sits in the last row
    logic row_end;    // last entry of its row
    idx_t col;        // column, also the row-buffer address
  } tmps_ctl_t;

endpackage

@@ rtl/triangle_max_path_sum.sv @@
// Top level: streamed maximum path sum over a number triangle.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    in_entry_value (16b signed)
//   out      output     out_valid/out_stall  out_max_sum (22b signed)
//   cfg      input      cfg_we               cfg_wdata (7b row count)
//
// One entry per cycle while in_stall is low; the row buffer is a 1-read/1-write RAM with forwarding.
// The last entry's transfer is registered in the sum stage, whose result then sets out_valid.
// rst_n is synchronous; row count returns to 1, no RAM clearing pass is needed.
// in_stall rises only when a finished result cannot enter a stalled output register.
module triangle_max_path_sum (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [tmps_pkg::CFG_W-1:0]             cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [tmps_pkg::VALUE_BITS-1:0] in_entry_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tmps_pkg::OUT_BITS-1:0]   out_max_sum
);
  import tmps_pkg::*;

  tmps_ctl_t ctl;
  logic      load;
  logic      hold;
  logic      we;
  idx_t      waddr;
  sum_t      wdata;
  sum_t      rd_data;

  assign in_stall = hold;
  assign load     = in_valid && !hold;

  tmps_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .load      (load),
    .ctl       (ctl)
  );

  tmps_ram #(
    .DEPTH (MAX_ROWS),
    .WIDTH (SUM_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (load),
    .raddr (ctl.col),
    .rdata (rd_data)
  );

  tmps_acc u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .load        (load),
    .ctl_in      (ctl),
    .entry_value (in_entry_value),
    .rd_data     (rd_data),
    .out_stall   (out_stall),
    .hold        (hold),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .out_valid   (out_valid),
    .out_max_sum (out_max_sum)
  );

endmodule

@@ rtl/tmps_ram.sv @@
// Simple dual-port RAM, one write and one registered read per cycle.
module tmps_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 23,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/tmps_seq.sv @@
// Row and column counters plus the latched effective row count.
module tmps_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [tmps_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       load,
  output tmps_pkg::tmps_ctl_t        ctl
);
  import tmps_pkg::*;

  logic [CNT_W-1:0] rows_r;
  logic [CNT_W-1:0] rows_nxt;
  idx_t             row_r;
  idx_t             col_r;
  logic             last_row;
  logic             row_end;

  // Clamp the programmed count into 1..MAX_ROWS
  always_comb begin
    if (cfg_wdata == '0) begin
      rows_nxt = CNT_W'(1);
    end else if (int'(cfg_wdata) > MAX_ROWS) begin
      rows_nxt = CNT_W'(MAX_ROWS);
    end else begin
      rows_nxt = CNT_W'(cfg_wdata);
    end
  end

  // Position flags for the entry at the head of the input
  always_comb begin
    last_row     = (CNT_W'(row_r) + CNT_W'(1)) >= rows_r;
    row_end      = (col_r == row_r);
    ctl.has_left  = (row_r != '0) && (col_r != '0);
    ctl.has_right = (col_r < row_r);
    ctl.bottom    = last_row;
    ctl.row_end   = row_end;
    ctl.col       = col_r;
  end

  // Step through the triangle; a config write restarts it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CNT_W'(1);
      row_r  <= '0;
      col_r  <= '0;
    end else if (cfg_we) begin
      rows_r <= rows_nxt;
      row_r  <= '0;
      col_r  <= '0;
    end else if (load) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + idx_t'(1);
      end else begin
        col_r <= col_r + idx_t'(1);
      end
    end
  end

endmodule

@@ rtl/tmps_acc.sv @@
// Sum stage: adds the entry to its best parent, writes the row buffer, tracks the maximum.
`include "triangle_max_path_sum_defines.svh"

module tmps_acc (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic                                   load,
  input  tmps_pkg::tmps_ctl_t                    ctl_in,
  input  logic signed [tmps_pkg::VALUE_BITS-1:0] entry_value,
  input  tmps_pkg::sum_t                         rd_data,
  input  logic                                   out_stall,
  output logic                                   hold,
  output logic                                   we,
  output tmps_pkg::idx_t                         waddr,
  output tmps_pkg::sum_t                         wdata,
  output logic                                   out_valid,
  output logic signed [tmps_pkg::OUT_BITS-1:0]   out_max_sum
);
  import tmps_pkg::*;

  logic                         s1_valid_r;
  tmps_ctl_t                    s1_ctl_r;
  logic signed [VALUE_BITS-1:0] s1_val_r;
  logic                         s1_fwd_r;
  sum_t                         wr_sum_r;
  sum_t                         left_hold_r;
  sum_t                         run_max_r;
  logic                         out_valid_r;
  logic signed [OUT_BITS-1:0]   out_sum_r;

  sum_t above;
  sum_t parent;
  sum_t sum;
  sum_t new_max;
  logic res;
  logic fire;
  logic fwd_nxt;

  // Parent selection and the one add of this stage
  always_comb begin
    above = s1_fwd_r ? wr_sum_r : rd_data;
    case ({s1_ctl_r.has_left, s1_ctl_r.has_right})
      2'b11:   parent = (left_hold_r > above) ? left_hold_r : above;
      2'b10:   parent = left_hold_r;
      2'b01:   parent = above;
      default: parent = '0;
    endcase
    sum = {{(SUM_W-VALUE_BITS){s1_val_r[VALUE_BITS-1]}}, s1_val_r} + parent;
    new_max = (sum > run_max_r) ? sum : run_max_r;
  end

  // Stage control: hold only when a result cannot enter a stalled output register
  always_comb begin
    res     = s1_ctl_r.bottom && s1_ctl_r.row_end;
    hold    = s1_valid_r && res && out_valid_r && out_stall;
    fire    = s1_valid_r && !hold;
    fwd_nxt = fire && (s1_ctl_r.col == ctl_in.col);
    we      = fire;
    waddr   = s1_ctl_r.col;
    wdata   = sum;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      left_hold_r <= '0;
      run_max_r   <= SUM_MIN;
    end else begin
      if (load) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (fire && res) begin
        out_valid_r <= 1'b1;
      end
      if (cfg_we) begin
        left_hold_r <= '0;
        run_max_r   <= SUM_MIN;
      end else if (fire) begin
        left_hold_r <= s1_ctl_r.row_end ? '0 : above;
        if (s1_ctl_r.bottom) begin
          run_max_r <= res ? SUM_MIN : new_max;
        end
      end
    end
  end

  // Payload registers; the forward flag covers a read of the slot written in the same cycle
  always_ff @(posedge clk) begin
    if (load) begin
      s1_ctl_r <= ctl_in;
      s1_val_r <= entry_value;
      s1_fwd_r <= fwd_nxt;
    end
    if (fire) begin
      wr_sum_r <= sum;
    end
    if (fire && res) begin
      out_sum_r <= new_max[OUT_BITS-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_max_sum = out_sum_r;

  `TMPS_ASSERT(a_hold_blocks_load, hold, !load, "transfer taken while sum stage is held")
  `TMPS_ASSERT_NEXT(a_result_lands, fire && res, out_valid_r, "finished triangle lost its result")
  `TMPS_ASSERT_NEXT(a_max_restarts, fire && res, run_max_r == SUM_MIN, "maximum not restarted")

endmodule

@@ test/triangle_max_path_sum_checker.sv @@
// Checker for the triangle path-sum block: follows transfers, predicts max_sum, compares.
module triangle_max_path_sum_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [tmps_pkg::CFG_W-1:0]             cfg_wdata,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic signed [tmps_pkg::VALUE_BITS-1:0] in_entry_value,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic signed [tmps_pkg::OUT_BITS-1:0]   out_max_sum,
  output int                                     fail_count,
  output int                                     pending
);
  import tmps_pkg::*;

  // Predictor state: row count, one row of best sums, position, held parent, bottom max
  logic [CFG_W-1:0] row_count_reg;
  sum_t             best_sums [MAX_ROWS];
  int unsigned      row_at;
  int unsigned      col_at;
  sum_t             left_hold;
  sum_t             bottom_max;

  // Max sums of completed triangles, oldest first
  logic signed [OUT_BITS-1:0] expected_max_sums [$];

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    fail_count = fail_count + 1;
  endtask

  // Row count zero acts as one row, anything past the buffer as a full buffer
  function automatic int unsigned rows_in_use();
    if (row_count_reg == 0) return 1;
    if (row_count_reg > MAX_ROWS) return MAX_ROWS;
    return int'(row_count_reg);
  endfunction

  task automatic restart_triangle();
    row_at     = 0;
    col_at     = 0;
    left_hold  = '0;
    bottom_max = SUM_MIN;
  endtask

  // One entry: add the better parent, track the bottom-row max, step the position
  task automatic fold_entry(input logic signed [VALUE_BITS-1:0] value);
    sum_t        entry;
    sum_t        above;
    sum_t        total;
    logic        has_left;
    logic        has_right;
    int unsigned rows;
    rows      = rows_in_use();
    entry     = SUM_W'(value);
    above     = '0;
    has_left  = (row_at > 0) && (col_at > 0);
    has_right = (row_at > 0) && (col_at < row_at);
    if (has_right) above = best_sums[col_at];

    if (has_left && has_right) total = entry + ((left_hold > above) ? left_hold : above);
    else if (has_left)         total = entry + left_hold;
    else if (has_right)        total = entry + above;
    else                       total = entry;

    // slot col_at is overwritten now, so keep its old value as the next left parent
    left_hold        = above;
    best_sums[col_at] = total;
    if (row_at + 1 >= rows && total > bottom_max) bottom_max = total;

    if (col_at >= row_at) begin
      col_at    = 0;
      left_hold = '0;
      if (row_at + 1 >= rows) begin
        expected_max_sums.push_back(bottom_max[OUT_BITS-1:0]);
        restart_triangle();
      end else begin
        row_at = row_at + 1;
      end
    end else begin
      col_at = col_at + 1;
    end
  endtask

  // Results are checked before this edge's input is folded in
  always @(posedge clk) begin : watch
    logic signed [OUT_BITS-1:0] want;
    if (!rst_n) begin
      row_count_reg = CFG_W'(1);
      foreach (best_sums[i]) best_sums[i] = '0;
      restart_triangle();
      expected_max_sums.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_max_sums.size() == 0) begin
          report($sformatf("max_sum %0d with no triangle completed", out_max_sum));
        end else begin
          want = expected_max_sums.pop_front();
          if (out_max_sum !== want)
            report($sformatf("max_sum %0d, expected %0d", out_max_sum, want));
        end
      end
      // a row-count write drops any partly loaded triangle
      if (cfg_we) begin
        row_count_reg = cfg_wdata;
        restart_triangle();
      end
      if (in_valid && !in_stall) fold_entry(in_entry_value);
    end
    pending <= expected_max_sums.size();
  end

endmodule

@@ test/tb.sv @@
// Testbench top: feeds triangles and row-count writes to the path-sum block, gives the verdict.
module tb;
  import tmps_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam logic signed [VALUE_BITS-1:0] ENTRY_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] ENTRY_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic                          clk            = 1'b0;
  logic                          rst_n          = 1'b0;
  logic                          cfg_we         = 1'b0;
  logic [CFG_W-1:0]              cfg_wdata      = '0;
  logic                          in_valid       = 1'b0;
  logic signed [VALUE_BITS-1:0]  in_entry_value = '0;
  logic                          out_stall      = 1'b0;
  logic                          in_stall;
  logic                          out_valid;
  logic signed [OUT_BITS-1:0]    out_max_sum;
  int                            fail_count;
  int                            pending;

  bit               quiet          = 1'b0;  // no gaps and no stalls while set
  int unsigned      stall_left     = 0;
  int unsigned      idle_cycles    = 0;
  int unsigned      random_entries = 0;
  logic [CFG_W-1:0] row_setting    = CFG_W'(1);

  always #5 clk = ~clk;

  triangle_max_path_sum i_dut (.*);

  triangle_max_path_sum_checker i_checker (.*);

  // Receiver: after each result transfer, stalls the output at random unless quiet is set
  always @(posedge clk) begin : out_pacing
    int unsigned hold;
    if (out_valid && !out_stall) begin
      hold = quiet ? 0 : $urandom_range(0, 4);
      stall_left <= hold;
      out_stall  <= (hold != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned rows_for_stimulus();
    if (row_setting == 0) return 1;
    if (row_setting > MAX_ROWS) return MAX_ROWS;
    return int'(row_setting);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_entry();
    case ($urandom_range(0, 7))
      0:       return ENTRY_MAX;
      1:       return ENTRY_MIN;
      2:       return VALUE_BITS'(int'($urandom_range(0, 6)) - 3);
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // One entry transfer, after a random gap
  task automatic put_entry(input logic signed [VALUE_BITS-1:0] value);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_entry_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every result is out and the pipeline is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_rows(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    row_setting  = value;
  endtask

  // Sends count entries of a triangle; all of a constant when fill is set
  task automatic put_triangle(input int unsigned count, input bit fill,
                              input logic signed [VALUE_BITS-1:0] fill_value);
    for (int unsigned k = 0; k < count; k++)
      put_entry(fill ? fill_value : pick_entry());
  endtask

  initial begin
    int unsigned rows;
    int unsigned total;
    int unsigned pick;
    int unsigned sent;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Row count out of reset is one: every entry is a whole triangle
    put_entry(ENTRY_MAX);
    put_entry(ENTRY_MIN);
    put_entry('0);
    put_entry(-16'sd1);
    put_entry(16'sd1);
    // Row count zero behaves as one row
    set_rows(CFG_W'(0));
    put_entry(ENTRY_MIN);
    put_entry(16'sh5A5A);
    // Two rows at both extremes
    set_rows(CFG_W'(2));
    put_triangle(3, 1'b1, ENTRY_MIN);
    put_triangle(3, 1'b1, ENTRY_MAX);
    // Partly loaded triangle abandoned by a row-count write
    set_rows(CFG_W'(3));
    put_entry(16'sd10);
    put_entry(-16'sd5);
    set_rows(CFG_W'(4));
    // Left parent wins at some entries, the one above at others
    put_entry(16'sd5);
    put_entry(16'sd3);
    put_entry(-16'sd7);
    put_entry(16'sd1);
    put_entry(16'sd100);
    put_entry(-16'sd1);
    put_entry(-16'sd2);
    put_entry(16'sd4);
    put_entry('0);
    put_entry(16'sd9);

    // Random triangles, mostly small, some broken off part way
    while (random_entries < 750) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      rows = 0;
      else if (pick == 1) rows = $urandom_range(9, 24);
      else                rows = $urandom_range(1, 8);
      if (rows != row_setting || $urandom_range(0, 3) == 0) set_rows(CFG_W'(rows));
      quiet = ($urandom_range(0, 4) == 0);
      for (int t = $urandom_range(1, 3); t > 0; t--) begin
        total = rows_for_stimulus() * (rows_for_stimulus() + 1) / 2;
        if (total > 1 && $urandom_range(0, 9) == 0) begin
          sent = $urandom_range(1, total - 1);
          put_triangle(sent, 1'b0, '0);
          set_rows(row_setting);
        end else begin
          sent = total;
          put_triangle(sent, 1'b0, '0);
        end
        random_entries += sent;
        // sender sometimes holds off until every result is back
        if ($urandom_range(0, 7) == 0) drain_results();
      end
    end

    // Larger triangles at both extreme entry values
    quiet = 1'b0;
    set_rows(CFG_W'(20));
    put_triangle(20 * 21 / 2, 1'b1, ENTRY_MIN);
    quiet = 1'b1;
    put_triangle(20 * 21 / 2, 1'b1, ENTRY_MAX);
    quiet = 1'b0;

    drain_results();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ triangle_max_path_sum.f @@
+incdir+rtl
rtl/tmps_pkg.sv
rtl/tmps_ram.sv
rtl/tmps_seq.sv
rtl/tmps_acc.sv
rtl/triangle_max_path_sum.sv
test/triangle_max_path_sum_checker.sv
test/tb.sv
